// ===== rtl/line_rasterizer_defines.svh =====
// Assertion macros for the line rasterizer.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define LRAS_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("line_rasterizer assertion failed");

// Next-cycle implication, disabled during reset.
`define LRAS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("line_rasterizer assertion failed");

`else

`define LRAS_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define LRAS_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== rtl/lras_pkg.sv =====
// Shared types, widths and helpers for the line rasterizer.
`default_nettype none

package lras_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 440;

    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int ERR_W   = 11;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Offset of the top row when rows are stored bottom first.
    localparam logic [ADDR_W-1:0] ROW_LAST_OFF =
        ADDR_W'(SCREEN_WIDTH * (SCREEN_HEIGHT - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_DOWN   = 1'b0,
        CFG_FRAME_BASE = 1'b1
    } cfg_index_t;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_TICK  = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd3
    } step_t;

    typedef struct packed {
        logic               req_type;
        logic [X_W-1:0]     start_x;
        logic [Y_W-1:0]     start_y;
        logic [X_W-1:0]     end_x;
        logic [Y_W-1:0]     end_y;
        logic [COLOR_W-1:0] pen_color;
    } in_word_t;

    typedef struct packed {
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pix_word_t;

    typedef struct packed {
        logic busy;
        logic emit;
    } core_stat_t;

    // Move a coordinate one place; a y coordinate passes zero-extended and
    // is truncated by the caller, which keeps the same wrap.
    function automatic logic [X_W-1:0] step_coord(logic [X_W-1:0] c, step_t s);
        logic [X_W-1:0] r;
        r = c;
        unique case (s)
            STEP_UP:   r = c + X_W'(1);
            STEP_DOWN: r = c - X_W'(1);
            default:   r = c;
        endcase
        return r;
    endfunction

    function automatic step_t dir_of(logic [X_W-1:0] from, logic [X_W-1:0] to);
        step_t d;
        if (to > from)
            d = STEP_UP;
        else if (to < from)
            d = STEP_DOWN;
        else
            d = STEP_NONE;
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lras_if.sv =====
// Request and pixel channel interfaces of the line rasterizer.
`default_nettype none

interface lras_req_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [lras_pkg::X_W-1:0]        start_x;
    logic [lras_pkg::Y_W-1:0]        start_y;
    logic [lras_pkg::X_W-1:0]        end_x;
    logic [lras_pkg::Y_W-1:0]        end_y;
    logic [lras_pkg::COLOR_W-1:0]    pen_color;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y, pen_color,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y, pen_color,
        output ready
    );
endinterface

interface lras_pix_if;
    logic                            valid;
    logic                            ready;
    logic [lras_pkg::X_W-1:0]        pixel_x;
    logic [lras_pkg::Y_W-1:0]        pixel_y;
    logic [lras_pkg::ADDR_W-1:0]     pixel_address;
    logic [lras_pkg::COLOR_W-1:0]    pixel_value;
    logic                            last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_address, pixel_value, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_address, pixel_value, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/line_rasterizer.sv =====
// Top level of the line rasterizer: handshake, config registers, two stages.
`default_nettype none

// Line rasterizer. A start word latches two endpoints and a pen color and
// yields nothing; each tick word while a line is running yields one pixel
// word (column, row, framebuffer address, color, last flag) until the line's
// major delta plus one pixels are out. One word is taken every clock unless
// both registers are full and the sink stalls. The error step runs into a
// pixel register, and the address add runs into the output register. Ticks
// with no line running and config writes are absorbed with no output.
`include "line_rasterizer_defines.svh"

module line_rasterizer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    lras_req_if.sink                               req,
    lras_pix_if.source                             pix,
    input  wire logic                              cfg_we,
    input  wire logic [lras_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lras_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                            top_down_reg;
    logic [lras_pkg::ADDR_W-1:0]     frame_base_reg;

    lras_pkg::in_word_t              in_word;
    lras_pkg::pix_word_t             core_pix;
    lras_pkg::core_stat_t            stat;
    logic                            accept;

    logic                            s1_valid_reg, s1_valid_next;
    lras_pkg::pix_word_t             s1_pix_reg;
    logic                            out_valid_reg, out_valid_next;
    lras_pkg::pix_word_t             out_pix_reg;
    logic [lras_pkg::ADDR_W-1:0]     out_addr_reg;
    logic [lras_pkg::ADDR_W-1:0]     addr;

    logic                            out_free;
    logic                            s1_move;

    always_comb
    begin
        in_word.req_type  = req.req_type;
        in_word.start_x   = req.start_x;
        in_word.start_y   = req.start_y;
        in_word.end_x     = req.end_x;
        in_word.end_y     = req.end_y;
        in_word.pen_color = req.pen_color;

        out_free  = !out_valid_reg || pix.ready;
        s1_move   = s1_valid_reg && out_free;
        req.ready = !s1_valid_reg || out_free;
        accept    = req.valid && req.ready;
    end

    always_comb
    begin
        s1_valid_next  = stat.emit ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (pix.ready ? 1'b0 : out_valid_reg);
    end

    lras_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (in_word),
        .pixel  (core_pix),
        .stat   (stat)
    );

    lras_addr u_addr (
        .pixel      (s1_pix_reg),
        .top_down   (top_down_reg),
        .frame_base (frame_base_reg),
        .address    (addr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_down_reg   <= 1'b1;
            frame_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (lras_pkg::cfg_index_t'(cfg_index))
                lras_pkg::CFG_TOP_DOWN:   top_down_reg   <= cfg_data[0];
                lras_pkg::CFG_FRAME_BASE: frame_base_reg <= cfg_data[lras_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (stat.emit)
            s1_pix_reg <= core_pix;
        if (s1_move)
        begin
            out_pix_reg  <= s1_pix_reg;
            out_addr_reg <= addr;
        end
    end

    assign pix.valid         = out_valid_reg;
    assign pix.pixel_x       = out_pix_reg.x;
    assign pix.pixel_y       = out_pix_reg.y;
    assign pix.pixel_address = out_addr_reg;
    assign pix.pixel_value   = out_pix_reg.color;
    assign pix.last_pixel    = out_pix_reg.last;

    `LRAS_ASSERT_NEXT(a_last_ends_run, clk, rst_n, stat.emit && core_pix.last, !stat.busy)
    `LRAS_ASSERT_NOW(a_stall_only_full, clk, rst_n, !req.ready, s1_valid_reg && out_valid_reg)
    `LRAS_ASSERT_NOW(a_emit_needs_room, clk, rst_n, stat.emit, stat.busy && req.ready)

endmodule

`default_nettype wire

// ===== rtl/lras_core.sv =====
// Line state and per-tick error step of the line rasterizer.
`default_nettype none

module lras_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire lras_pkg::in_word_t     req,
    output lras_pkg::pix_word_t         pixel,
    output lras_pkg::core_stat_t        stat
);

    logic                          busy_reg, busy_next;
    logic [lras_pkg::X_W-1:0]      cur_x_reg, cur_x_next;
    logic [lras_pkg::Y_W-1:0]      cur_y_reg, cur_y_next;
    logic [lras_pkg::ERR_W-1:0]    err_reg, err_next;
    logic [lras_pkg::X_W-1:0]      major_reg, major_next;
    logic [lras_pkg::X_W-1:0]      minor_reg, minor_next;
    logic [lras_pkg::X_W-1:0]      left_reg, left_next;
    lras_pkg::step_t               step_x_reg, step_x_next;
    lras_pkg::step_t               step_y_reg, step_y_next;
    logic                          x_major_reg, x_major_next;
    logic [lras_pkg::COLOR_W-1:0]  color_reg, color_next;

    logic [lras_pkg::X_W-1:0]      dx;
    logic [lras_pkg::Y_W-1:0]      dy;
    logic [lras_pkg::ERR_W-1:0]    err_add;
    logic                          minor_step;
    logic [lras_pkg::X_W-1:0]      px;
    logic [lras_pkg::Y_W-1:0]      py;
    logic                          last;
    logic                          emit;

    always_comb
    begin
        dx = (req.end_x >= req.start_x) ? req.end_x - req.start_x
                                        : req.start_x - req.end_x;
        dy = (req.end_y >= req.start_y) ? req.end_y - req.start_y
                                        : req.start_y - req.end_y;

        // Error step: grow by minor delta, pull back by major when it passes.
        err_add    = err_reg + lras_pkg::ERR_W'(minor_reg);
        minor_step = err_add > lras_pkg::ERR_W'(major_reg);

        px = cur_x_reg;
        py = cur_y_reg;
        if (minor_step)
        begin
            if (x_major_reg)
                py = lras_pkg::Y_W'(lras_pkg::step_coord(
                         lras_pkg::X_W'(cur_y_reg), step_y_reg));
            else
                px = lras_pkg::step_coord(cur_x_reg, step_x_reg);
        end
        last = (left_reg == '0);
        emit = accept && (req.req_type == lras_pkg::REQ_TICK) && busy_reg;

        busy_next    = busy_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        err_next     = err_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        left_next    = left_reg;
        step_x_next  = step_x_reg;
        step_y_next  = step_y_reg;
        x_major_next = x_major_reg;
        color_next   = color_reg;

        if (accept && req.req_type == lras_pkg::REQ_START)
        begin
            cur_x_next   = req.start_x;
            cur_y_next   = req.start_y;
            step_x_next  = lras_pkg::dir_of(req.start_x, req.end_x);
            step_y_next  = lras_pkg::dir_of(lras_pkg::X_W'(req.start_y),
                                            lras_pkg::X_W'(req.end_y));
            color_next   = req.pen_color;
            err_next     = '0;
            x_major_next = lras_pkg::X_W'(dy) <= dx;
            major_next   = x_major_next ? dx : lras_pkg::X_W'(dy);
            minor_next   = x_major_next ? lras_pkg::X_W'(dy) : dx;
            left_next    = major_next;
            busy_next    = 1'b1;
        end
        else if (emit)
        begin
            err_next = minor_step ? err_add - lras_pkg::ERR_W'(major_reg) : err_add;
            // Advance the major coordinate after the plot.
            if (x_major_reg)
            begin
                cur_x_next = lras_pkg::step_coord(px, step_x_reg);
                cur_y_next = py;
            end
            else
            begin
                cur_x_next = px;
                cur_y_next = lras_pkg::Y_W'(lras_pkg::step_coord(
                                 lras_pkg::X_W'(py), step_y_reg));
            end
            if (last)
                busy_next = 1'b0;
            else
                left_next = left_reg - lras_pkg::X_W'(1);
        end

        pixel.x     = px;
        pixel.y     = py;
        pixel.color = color_reg;
        pixel.last  = last;
        stat.busy   = busy_reg;
        stat.emit   = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            err_reg     <= '0;
            major_reg   <= '0;
            minor_reg   <= '0;
            left_reg    <= '0;
            step_x_reg  <= lras_pkg::STEP_NONE;
            step_y_reg  <= lras_pkg::STEP_NONE;
            x_major_reg <= 1'b0;
            color_reg   <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            err_reg     <= err_next;
            major_reg   <= major_next;
            minor_reg   <= minor_next;
            left_reg    <= left_next;
            step_x_reg  <= step_x_next;
            step_y_reg  <= step_y_next;
            x_major_reg <= x_major_next;
            color_reg   <= color_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lras_addr.sv =====
// Framebuffer address of a pixel in either row order.
`default_nettype none

module lras_addr (
    input  wire lras_pkg::pix_word_t            pixel,
    input  wire logic                           top_down,
    input  wire logic [lras_pkg::ADDR_W-1:0]    frame_base,
    output logic [lras_pkg::ADDR_W-1:0]         address
);

    logic [lras_pkg::ADDR_W-1:0] row;
    logic [lras_pkg::ADDR_W-1:0] off;

    always_comb
    begin
        row = lras_pkg::ADDR_W'(pixel.y) * lras_pkg::ADDR_W'(lras_pkg::SCREEN_WIDTH);
        off = top_down ? row : lras_pkg::ROW_LAST_OFF - row;
        address = frame_base + off + lras_pkg::ADDR_W'(pixel.x);
    end

endmodule

`default_nettype wire

// ===== tb/line_rasterizer_tb.sv =====
// Testbench for line_rasterizer: directed table and random lines against a predictor.
`timescale 1ns / 100ps

module line_rasterizer_tb;

    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 50;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 50;
    localparam int X_MAX           = lras_pkg::SCREEN_WIDTH - 1;
    localparam int Y_MAX           = lras_pkg::SCREEN_HEIGHT - 1;

    localparam lras_pkg::req_type_t DO_START = lras_pkg::REQ_START;
    localparam lras_pkg::req_type_t DO_TICK  = lras_pkg::REQ_TICK;

    typedef struct packed {
        logic [lras_pkg::X_W-1:0]     x;
        logic [lras_pkg::Y_W-1:0]     y;
        logic [lras_pkg::ADDR_W-1:0]  addr;
        logic [lras_pkg::COLOR_W-1:0] value;
        logic                         last;
    } pixel_t;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_PIXEL
    } check_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_HEAVY,
        IDLE_LIGHT
    } idle_t;

    typedef struct packed {
        lras_pkg::in_word_t w;
        check_t             chk;
        pixel_t             want;
    } dir_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [lras_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lras_pkg::CFG_DATA_W-1:0] cfg_data;

    lras_req_if req_ch ();
    lras_pix_if pix_ch ();

    line_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .pix       (pix_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state and register copies
    logic                         line_busy;
    logic [lras_pkg::X_W-1:0]     pos_x;
    logic [lras_pkg::Y_W-1:0]     pos_y;
    logic [lras_pkg::ERR_W-1:0]   err_acc;
    logic [lras_pkg::X_W-1:0]     run_major;
    logic [lras_pkg::X_W-1:0]     run_minor;
    logic [lras_pkg::X_W-1:0]     run_remaining;
    lras_pkg::step_t              dir_x;
    lras_pkg::step_t              dir_y;
    logic                         along_x;
    logic [lras_pkg::COLOR_W-1:0] pen;
    logic                         cfg_top_down;
    logic [lras_pkg::ADDR_W-1:0]  cfg_base;

    pixel_t   pixels_due[$];
    dir_row_t directed_rows [25];
    idle_t    src_mode;
    idle_t    sink_mode;
    int       errors;
    int       words_sent;
    int       lines_started;
    int       pixels_checked;
    int       quiet_cycles;

    function automatic lras_pkg::step_t heading(int from, int to);
        lras_pkg::step_t s;
        if (to > from)
            s = lras_pkg::STEP_UP;
        else if (to < from)
            s = lras_pkg::STEP_DOWN;
        else
            s = lras_pkg::STEP_NONE;
        return s;
    endfunction

    function automatic logic [lras_pkg::X_W-1:0] nudge(logic [lras_pkg::X_W-1:0] c,
                                                        lras_pkg::step_t s);
        logic [lras_pkg::X_W-1:0] r;
        case (s)
            lras_pkg::STEP_UP:   r = c + 1'b1;
            lras_pkg::STEP_DOWN: r = c - 1'b1;
            default:             r = c;
        endcase
        return r;
    endfunction

    // Advance the line state by one word; return 1 when a pixel comes out.
    function automatic bit rasterize(input lras_pkg::in_word_t w, output pixel_t p);
        int                          dx;
        int                          dy;
        bit                          made;
        logic [lras_pkg::ADDR_W-1:0] row_off;
        logic [lras_pkg::ADDR_W-1:0] off;
        p = '0;
        made = 1'b0;
        if (w.req_type == lras_pkg::REQ_START)
        begin
            dx = (w.end_x >= w.start_x) ? w.end_x - w.start_x : w.start_x - w.end_x;
            dy = (w.end_y >= w.start_y) ? w.end_y - w.start_y : w.start_y - w.end_y;
            pos_x = w.start_x;
            pos_y = w.start_y;
            dir_x = heading(w.start_x, w.end_x);
            dir_y = heading(w.start_y, w.end_y);
            pen = w.pen_color;
            err_acc = '0;
            // ties go to x
            along_x = (dy <= dx);
            run_major = along_x ? lras_pkg::X_W'(dx) : lras_pkg::X_W'(dy);
            run_minor = along_x ? lras_pkg::X_W'(dy) : lras_pkg::X_W'(dx);
            run_remaining = run_major;
            line_busy = 1'b1;
        end
        else if (line_busy)
        begin
            err_acc = err_acc + lras_pkg::ERR_W'(run_minor);
            if (err_acc > lras_pkg::ERR_W'(run_major))
            begin
                err_acc = err_acc - lras_pkg::ERR_W'(run_major);
                if (along_x)
                    pos_y = lras_pkg::Y_W'(nudge(lras_pkg::X_W'(pos_y), dir_y));
                else
                    pos_x = nudge(pos_x, dir_x);
            end
            row_off = lras_pkg::ADDR_W'(lras_pkg::SCREEN_WIDTH) * lras_pkg::ADDR_W'(pos_y);
            off = cfg_top_down ? row_off
                               : lras_pkg::ADDR_W'(lras_pkg::SCREEN_WIDTH *
                                                   (lras_pkg::SCREEN_HEIGHT - 1)) - row_off;
            p.x = pos_x;
            p.y = pos_y;
            p.addr = cfg_base + off + lras_pkg::ADDR_W'(pos_x);
            p.value = pen;
            p.last = (run_remaining == '0);
            if (along_x)
                pos_x = nudge(pos_x, dir_x);
            else
                pos_y = lras_pkg::Y_W'(nudge(lras_pkg::X_W'(pos_y), dir_y));
            if (p.last)
                line_busy = 1'b0;
            else
                run_remaining = run_remaining - 1'b1;
            made = 1'b1;
        end
        return made;
    endfunction

    function automatic int draw_gap(idle_t mode);
        int g;
        case (mode)
            IDLE_NONE:  g = 0;
            IDLE_HEAVY: g = $urandom_range(0, 15);
            default:    g = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : 0;
        endcase
        return g;
    endfunction

    function automatic dir_row_t row_of(logic kind, int x1, int y1, int x2, int y2,
                                        int color, check_t chk, pixel_t want);
        dir_row_t r;
        r.w.req_type  = kind;
        r.w.start_x   = lras_pkg::X_W'(x1);
        r.w.start_y   = lras_pkg::Y_W'(y1);
        r.w.end_x     = lras_pkg::X_W'(x2);
        r.w.end_y     = lras_pkg::Y_W'(y2);
        r.w.pen_color = lras_pkg::COLOR_W'(color);
        r.chk         = chk;
        r.want        = want;
        return r;
    endfunction

    // Tick with random content in the fields that a tick ignores
    function automatic lras_pkg::in_word_t tick_word();
        lras_pkg::in_word_t w;
        w.req_type  = lras_pkg::REQ_TICK;
        w.start_x   = lras_pkg::X_W'($urandom_range(0, X_MAX));
        w.start_y   = lras_pkg::Y_W'($urandom_range(0, Y_MAX));
        w.end_x     = lras_pkg::X_W'($urandom_range(0, X_MAX));
        w.end_y     = lras_pkg::Y_W'($urandom_range(0, Y_MAX));
        w.pen_color = lras_pkg::COLOR_W'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
                         $time, name, want, want, got, got);
        end
    endfunction

    task automatic send_word(input lras_pkg::in_word_t w, input check_t chk,
                             input pixel_t typed);
        int     gap;
        bit     counted;
        bit     made;
        pixel_t predicted;
        gap = draw_gap(src_mode);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= w.req_type;
        req_ch.start_x   <= w.start_x;
        req_ch.start_y   <= w.start_y;
        req_ch.end_x     <= w.end_x;
        req_ch.end_y     <= w.end_y;
        req_ch.pen_color <= w.pen_color;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        // ticks with no line running are absorbed and do not count
        counted = (w.req_type == lras_pkg::REQ_START) || line_busy;
        if (w.req_type == lras_pkg::REQ_START)
            lines_started++;
        made = rasterize(w, predicted);
        if (chk == CHK_PIXEL)
            pixels_due.push_back(typed);
        else if (chk == CHK_PREDICT && made)
            pixels_due.push_back(predicted);
        if (counted)
            words_sent++;
    endtask

    // Drop valid, wait for every pending pixel, then let the pipeline settle
    task automatic drain_pixels(int settle);
        req_ch.valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic run_line();
        lras_pkg::in_word_t w;
        int                 x1;
        int                 y1;
        int                 x2;
        int                 y2;
        int                 span;
        int                 ticks;
        int                 pick;
        if ($urandom_range(0, 11) == 0)
        begin
            // stray ticks, often with no line running
            repeat ($urandom_range(1, 3))
                send_word(tick_word(), CHK_PREDICT, '0);
        end
        else
        begin
            x1 = $urandom_range(0, X_MAX);
            y1 = $urandom_range(0, Y_MAX);
            if ($urandom_range(0, 39) == 0)
            begin
                x2 = $urandom_range(0, X_MAX);
                y2 = $urandom_range(0, Y_MAX);
            end
            else
            begin
                x2 = x1 + int'($urandom_range(0, 24)) - 12;
                y2 = y1 + int'($urandom_range(0, 24)) - 12;
                x2 = (x2 < 0) ? 0 : (x2 > X_MAX) ? X_MAX : x2;
                y2 = (y2 < 0) ? 0 : (y2 > Y_MAX) ? Y_MAX : y2;
            end
            w.req_type  = lras_pkg::REQ_START;
            w.start_x   = lras_pkg::X_W'(x1);
            w.start_y   = lras_pkg::Y_W'(y1);
            w.end_x     = lras_pkg::X_W'(x2);
            w.end_y     = lras_pkg::Y_W'(y2);
            w.pen_color = lras_pkg::COLOR_W'($urandom_range(0, 255));
            send_word(w, CHK_PREDICT, '0);
            span = (x2 > x1) ? x2 - x1 : x1 - x2;
            if (((y2 > y1) ? y2 - y1 : y1 - y2) > span)
                span = (y2 > y1) ? y2 - y1 : y1 - y2;
            pick = $urandom_range(0, 9);
            // mostly full lines; some cut short by a restart, some overrun
            if (pick == 0)
                ticks = $urandom_range(0, span);
            else if (pick == 1)
                ticks = span + 1 + $urandom_range(1, 3);
            else
                ticks = span + 1;
            repeat (ticks)
                send_word(tick_word(), CHK_PREDICT, '0);
        end
    endtask

    // Pixel sink: stall at random, check every accepted word
    initial
    begin
        int     stall;
        pixel_t want;
        pixel_t got;
        pix_ch.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = draw_gap(sink_mode);
            if (stall > 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pix_ch.ready <= 1'b1;
            do @(posedge clk); while (pix_ch.valid !== 1'b1);
            got = {pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.pixel_address,
                   pix_ch.pixel_value, pix_ch.last_pixel};
            if (pixels_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected pixel x=%0d y=%0d addr=0x%0h value=%0d last=%0b",
                             $time, got.x, got.y, got.addr, got.value, got.last);
            end
            else
            begin
                want = pixels_due.pop_front();
                pixels_checked++;
                compare_field("pixel_x", 32'(want.x), 32'(got.x));
                compare_field("pixel_y", 32'(want.y), 32'(got.y));
                compare_field("pixel_address", want.addr, got.addr);
                compare_field("pixel_value", 32'(want.value), 32'(got.value));
                compare_field("last_pixel", 32'(want.last), 32'(got.last));
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            quiet_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (pix_ch.valid && pix_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int           phase_base;
        logic         top;
        logic [31:0]  base;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= lras_pkg::CFG_TOP_DOWN;
        cfg_data         <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= lras_pkg::REQ_START;
        req_ch.start_x   <= '0;
        req_ch.start_y   <= '0;
        req_ch.end_x     <= '0;
        req_ch.end_y     <= '0;
        req_ch.pen_color <= '0;

        line_busy = 1'b0;
        pos_x = '0;
        pos_y = '0;
        err_acc = '0;
        run_major = '0;
        run_minor = '0;
        run_remaining = '0;
        dir_x = lras_pkg::STEP_NONE;
        dir_y = lras_pkg::STEP_NONE;
        along_x = 1'b0;
        pen = '0;
        cfg_top_down = 1'b1;
        cfg_base = '0;
        errors = 0;
        words_sent = 0;
        lines_started = 0;
        pixels_checked = 0;
        src_mode = IDLE_HEAVY;
        sink_mode = IDLE_HEAVY;

        // Directed rows run with the registers at their reset values
        directed_rows[0]  = row_of(DO_TICK, X_MAX, Y_MAX, X_MAX, Y_MAX, 255, CHK_NONE, '0);
        directed_rows[1]  = row_of(DO_START, 0, 0, 0, 0, 8'hAB, CHK_PREDICT, '0);
        directed_rows[2]  = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PIXEL,
                                   pixel_t'({10'd0, 9'd0, 32'd0, 8'hAB, 1'b1}));
        directed_rows[3]  = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_NONE, '0);
        directed_rows[4]  = row_of(DO_START, X_MAX, Y_MAX, X_MAX, Y_MAX, 255, CHK_PREDICT, '0);
        directed_rows[5]  = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PIXEL,
                                   pixel_t'({10'd639, 9'd439, 32'd281599, 8'hFF, 1'b1}));
        directed_rows[6]  = row_of(DO_START, 0, 0, 3, 0, 0, CHK_PREDICT, '0);
        directed_rows[7]  = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        directed_rows[8]  = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        directed_rows[9]  = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        directed_rows[10] = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        directed_rows[11] = row_of(DO_START, 5, 10, 5, 6, 8'h5A, CHK_PREDICT, '0);
        directed_rows[12] = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        directed_rows[13] = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        directed_rows[14] = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        directed_rows[15] = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        directed_rows[16] = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        directed_rows[17] = row_of(DO_START, 10, 10, 14, 14, 8'hC3, CHK_PREDICT, '0);
        directed_rows[18] = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        directed_rows[19] = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        // restart mid-line with the widest deltas
        directed_rows[20] = row_of(DO_START, X_MAX, 0, 0, Y_MAX, 8'h80, CHK_PREDICT, '0);
        directed_rows[21] = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PIXEL,
                                   pixel_t'({10'd639, 9'd0, 32'd639, 8'h80, 1'b0}));
        directed_rows[22] = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);
        directed_rows[23] = row_of(DO_START, 2, 3, 9, 1, 8'h3C, CHK_PREDICT, '0);
        directed_rows[24] = row_of(DO_TICK, 0, 0, 0, 0, 0, CHK_PREDICT, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].chk, directed_rows[i].want);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_pixels(SETTLE_CYCLES);
            case (phase)
                0:       begin top = 1'b0; base = 32'h0000_0000; end
                1:       begin top = 1'b1; base = 32'hFFFF_FFFF; end
                2:       begin top = 1'b0; base = 32'hFFFF_FFFF; end
                3:       begin top = 1'b1; base = 32'h0000_0000; end
                default: begin top = 1'($urandom_range(0, 1)); base = $urandom; end
            endcase
            // hold write enable across both registers
            cfg_we    <= 1'b1;
            cfg_index <= lras_pkg::CFG_TOP_DOWN;
            cfg_data  <= {31'b0, top};
            @(posedge clk);
            cfg_index <= lras_pkg::CFG_FRAME_BASE;
            cfg_data  <= base;
            @(posedge clk);
            cfg_we    <= 1'b0;
            cfg_top_down = top;
            cfg_base = base;

            src_mode  = idle_t'(phase % 3);
            sink_mode = idle_t'((phase + phase / 3) % 3);
            phase_base = words_sent;
            while (words_sent - phase_base < WORDS_PER_PHASE)
                run_line();
        end

        drain_pixels(DRAIN_CYCLES);
        $display("summary: %0d words sent, %0d lines started, %0d pixels checked",
                 words_sent, lines_started, pixels_checked);
        $display("summary: %0d register settings, %0d mismatches", PHASES + 1, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lras_pkg.sv
rtl/lras_if.sv
rtl/lras_core.sv
rtl/lras_addr.sv
rtl/line_rasterizer.sv
tb/line_rasterizer_tb.sv
